[src/bpol_pkg.sv]
// ----------------------------------------------------------------------------
// bpol_pkg
// Shared types and register codes for the byte pattern occurrence locator.
// ----------------------------------------------------------------------------
package bpol_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned ADJUST_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_MID  = 3'd1,
    REG_PAT_HIGH = 3'd2,
    REG_LENGTH   = 3'd3,
    REG_MODE     = 3'd4,
    REG_INDEX    = 3'd5,
    REG_ADJUST   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    MODE_NTH  = 1'b0,
    MODE_LAST = 1'b1
  } search_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                       found;
    logic signed [OFFSET_W-1:0] match_offset;
  } out_item_t;

  // Control registers other than the pattern bytes.
  typedef struct packed {
    logic [LEN_W-1:0]           pattern_length;
    search_mode_e               search_mode;
    logic [COUNT_W-1:0]         occurrence_index;
    logic signed [ADJUST_W-1:0] offset_adjust;
  } ctrl_t;

endpackage

[src/bpol_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bpol_cfg_regs
// Configuration register file: pattern bytes and search controls.
// ----------------------------------------------------------------------------
module bpol_cfg_regs import bpol_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [63:0]                    cfg_data_i,
  output logic [MAX_PATTERN_BYTES*8-1:0] pattern_o,
  output ctrl_t                          ctrl_o
);

  logic [7:0] pat_q [MAX_PATTERN_BYTES];
  ctrl_t      ctrl_q;
  logic       we;
  logic       pat_we;
  logic [1:0] pat_grp;

  assign cfg_ready_o = 1'b1;
  assign we          = cfg_valid_i;

  // Each pattern register carries eight bytes; only bytes that fit are kept.
  always_comb begin
    pat_we  = 1'b0;
    pat_grp = 2'd0;
    case (cfg_reg_e'(cfg_index_i))
      REG_PAT_LOW: begin
        pat_we  = we;
        pat_grp = 2'd0;
      end
      REG_PAT_MID: begin
        pat_we  = we;
        pat_grp = 2'd1;
      end
      REG_PAT_HIGH: begin
        pat_we  = we;
        pat_grp = 2'd2;
      end
      default: begin
        pat_we  = 1'b0;
        pat_grp = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        pat_q[k] <= 8'h00;
      end
    end else if (pat_we) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        if (pat_grp == 2'(k >> 3)) begin
          pat_q[k] <= cfg_data_i[(k & 7)*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.pattern_length   <= LEN_W'(1);
      ctrl_q.search_mode      <= MODE_NTH;
      ctrl_q.occurrence_index <= '0;
      ctrl_q.offset_adjust    <= '0;
    end else if (we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_LENGTH: ctrl_q.pattern_length   <= cfg_data_i[LEN_W-1:0];
        REG_MODE:   ctrl_q.search_mode      <= search_mode_e'(cfg_data_i[0]);
        REG_INDEX:  ctrl_q.occurrence_index <= cfg_data_i[COUNT_W-1:0];
        REG_ADJUST: ctrl_q.offset_adjust    <= cfg_data_i[ADJUST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      pattern_o[k*8 +: 8] = pat_q[k];
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

[src/bpol_match.sv]
// ----------------------------------------------------------------------------
// bpol_match
// Compares one image byte with the expected pattern byte and advances the
// naive match progress.
// ----------------------------------------------------------------------------
module bpol_match import bpol_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 24,
  localparam int unsigned PROG_W = $clog2(MAX_PATTERN_BYTES + 1),
  localparam int unsigned IDX_W  = $clog2(MAX_PATTERN_BYTES)
) (
  input  logic [7:0]                     data_byte_i,
  input  logic [PROG_W-1:0]              progress_i,
  input  logic [MAX_PATTERN_BYTES*8-1:0] pattern_i,
  input  logic [LEN_W-1:0]               pattern_length_i,
  output logic [PROG_W-1:0]              progress_o,
  output logic                           matched_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN_BYTES);

  logic [LEN_W-1:0]  len_raw;
  logic [PROG_W-1:0] len_eff;
  logic [PROG_W-1:0] prog_eff;
  logic [PROG_W-1:0] prog_inc;
  logic [7:0]        expected;

  always_comb begin
    if (pattern_length_i == '0) begin
      len_raw = LEN_W'(1);
    end else if (pattern_length_i > MaxLen) begin
      len_raw = MaxLen;
    end else begin
      len_raw = pattern_length_i;
    end
    len_eff = PROG_W'(len_raw);

    // A shortened pattern may leave progress beyond the new length.
    prog_eff = (progress_i >= len_eff) ? '0 : progress_i;
    expected = pattern_i[prog_eff[IDX_W-1:0]*8 +: 8];
    prog_inc = prog_eff + PROG_W'(1);

    matched_o  = 1'b0;
    progress_o = '0;
    if (data_byte_i == expected) begin
      if (prog_inc >= len_eff) begin
        matched_o = 1'b1;
      end else begin
        progress_o = prog_inc;
      end
    end
  end

endmodule

[src/byte_pattern_occurrence_locator.sv]
// A byte's result, if any, passes the input register, loaded at acceptance,
// and then the result register. Throughput: one byte per cycle, set by the
// combinational compare and counter update between the two registers, but a
// last byte waits while a held result is stalled.
// Reset: configuration returns to its defaults (pattern length one, all else
// zero), search state is cleared and both registers are emptied.
// ----------------------------------------------------------------------------
// byte_pattern_occurrence_locator
// Streams an image byte by byte, counts pattern matches and reports the
// adjusted position of the wanted (nth or last) occurrence on the last byte.
// ----------------------------------------------------------------------------
module byte_pattern_occurrence_locator import bpol_pkg::*; #(
  parameter int unsigned POSITION_WIDTH    = 32,
  parameter int unsigned MAX_PATTERN_BYTES = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  localparam int unsigned PROG_W = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned SUM_W  = ((POSITION_WIDTH > OFFSET_W) ? POSITION_WIDTH : OFFSET_W) + 2;
  localparam logic signed [SUM_W-1:0] OffMax = SUM_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] OffMin = ~OffMax;

  logic [MAX_PATTERN_BYTES*8-1:0] pattern;
  ctrl_t                          ctrl;

  // Input register.
  in_item_t in_q;
  logic     in_valid_q;
  logic     in_ready;
  logic     proc;

  // Search state.
  logic [PROG_W-1:0]          progress_q, progress_d;
  logic [COUNT_W-1:0]         seen_q, seen_d;
  logic [POSITION_WIDTH-1:0]  pos_q, pos_d;
  logic signed [OFFSET_W-1:0] held_q, held_d;
  logic                       hit_q, hit_d;
  logic                       done_q, done_d;

  // Result register.
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  logic [PROG_W-1:0]          prog_next;
  logic                       matched;
  logic signed [SUM_W-1:0]    sum;
  logic signed [OFFSET_W-1:0] adj_offset;

  bpol_cfg_regs #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pattern_o  (pattern),
    .ctrl_o     (ctrl)
  );

  bpol_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_match (
    .data_byte_i     (in_q.data_byte),
    .progress_i      (progress_q),
    .pattern_i       (pattern),
    .pattern_length_i(ctrl.pattern_length),
    .progress_o      (prog_next),
    .matched_o       (matched)
  );

  // A byte without the end mark never waits on the result register.
  assign proc       = in_valid_q && (!in_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_ready   = !in_valid_q || proc;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  always_comb begin
    sum = SUM_W'(pos_q) + SUM_W'(ctrl.offset_adjust);
    if (sum > OffMax) begin
      adj_offset = OffMax[OFFSET_W-1:0];
    end else if (sum < OffMin) begin
      adj_offset = OffMin[OFFSET_W-1:0];
    end else begin
      adj_offset = sum[OFFSET_W-1:0];
    end
  end

  always_comb begin
    progress_d  = progress_q;
    seen_d      = seen_q;
    pos_d       = pos_q;
    held_d      = held_q;
    hit_d       = hit_q;
    done_d      = done_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (proc) begin
      if (!done_q) begin
        progress_d = prog_next;
        if (matched) begin
          if (ctrl.search_mode == MODE_LAST) begin
            held_d = adj_offset;
            hit_d  = 1'b1;
          end else if (seen_q == ctrl.occurrence_index) begin
            held_d = adj_offset;
            hit_d  = 1'b1;
            done_d = 1'b1;
          end
          if (seen_q != '1) begin
            seen_d = seen_q + COUNT_W'(1);
          end
        end
        if (pos_q != '1) begin
          pos_d = pos_q + POSITION_WIDTH'(1);
        end
      end

      if (in_q.last_byte) begin
        out_d.found        = hit_d;
        out_d.match_offset = held_d;
        out_valid_d        = 1'b1;
        progress_d         = '0;
        seen_d             = '0;
        pos_d              = '0;
        held_d             = '1;
        hit_d              = 1'b0;
        done_d             = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      progress_q  <= '0;
      seen_q      <= '0;
      pos_q       <= '0;
      held_q      <= '1;
      hit_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      progress_q  <= progress_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      held_q      <= held_d;
      hit_q       <= hit_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
